// File: rtl/core/lrrg_pkg.sv
// Shared types, constants and wheel functions for the LED ring rainbow generator.
package lrrg_pkg;

  localparam int PHASE_W   = 13;
  localparam int IDX_W     = 11;
  localparam int COUNT_W   = 7;
  localparam int POS_W     = 6;
  localparam int COLOR_W   = 8;
  localparam int ANGLE_W   = 12;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [IDX_W-1:0]   WHEEL_STEPS = 11'd1536;
  localparam logic [PHASE_W-1:0] WHEEL_STEPS_P = 13'd1536;

  typedef enum logic {
    REQ_SET_ANGLE = 1'b0,
    REQ_UPDATE    = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_MODE = 1'b0,
    CFG_LED_COUNT  = 1'b1
  } cfg_reg_t;

  // Update request as it travels from the front to the back.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Mode three wraps around to one repetition.
  function automatic logic [1:0] cycle_shift(input logic [MODE_W-1:0] mode);
    logic [1:0] s;
    case (mode)
      2'd1:    s = 2'd1;
      2'd2:    s = 2'd2;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  // Reduces a value below 8192 modulo the wheel size.
  function automatic logic [IDX_W-1:0] wheel_mod(input logic [PHASE_W-1:0] v);
    logic [PHASE_W-1:0] r;
    if (v >= 13'd7680) begin
      r = v - 13'd7680;
    end else if (v >= 13'd6144) begin
      r = v - 13'd6144;
    end else if (v >= 13'd4608) begin
      r = v - 13'd4608;
    end else if (v >= 13'd3072) begin
      r = v - 13'd3072;
    end else if (v >= WHEEL_STEPS_P) begin
      r = v - WHEEL_STEPS_P;
    end else begin
      r = v;
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic rgb_t wheel_rgb(input logic [IDX_W-1:0] idx);
    rgb_t c;
    logic [COLOR_W-1:0] up;
    logic [COLOR_W-1:0] down;
    up   = idx[COLOR_W-1:0];
    down = ~up;
    unique case (idx[IDX_W-1:COLOR_W])
      3'd0: c = '{red: up,    green: 8'd0,   blue: 8'd255};
      3'd1: c = '{red: 8'd255, green: 8'd0,  blue: down};
      3'd2: c = '{red: 8'd255, green: up,    blue: 8'd0};
      3'd3: c = '{red: down,  green: 8'd255, blue: 8'd0};
      3'd4: c = '{red: 8'd0,  green: 8'd255, blue: up};
      default: c = '{red: 8'd0, green: down, blue: 8'd255};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/led_ring_rainbow_generator.sv
// Top level of the LED ring rainbow generator: configuration registers and wiring.
// A set-angle request only updates the phase and produces no result; up to two updates wait.
// An idle back end takes an update from the queue, runs the pitch divider, then a setup
// state, and registers each color; it takes no new update until its frame is done.
// Colors follow one per cycle while the output slot is free, that is empty or being popped.
// Reset is synchronous and active low; phase, mode 0 and a 24-LED count are restored.
module led_ring_rainbow_generator
  import lrrg_pkg::*;
#(
  parameter int MAX_LEDS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [ANGLE_W-1:0]    in_angle,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [POS_W-1:0]      out_led_position,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0]  cycle_mode_r, cycle_mode_nxt;
  logic [COUNT_W-1:0] led_count_r, led_count_nxt;
  logic [1:0]         shift;
  logic [COUNT_W-1:0] count;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  cmd_t               q_cmd;
  cmd_t               q_head;

  always_comb begin
    cycle_mode_nxt = cycle_mode_r;
    led_count_nxt  = led_count_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CYCLE_MODE: cycle_mode_nxt = cfg_data[MODE_W-1:0];
        CFG_LED_COUNT:  led_count_nxt  = cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_mode_r <= '0;
      led_count_r  <= 7'd24;
    end else begin
      cycle_mode_r <= cycle_mode_nxt;
      led_count_r  <= led_count_nxt;
    end
  end

  assign shift = cycle_shift(cycle_mode_r);
  assign count = (led_count_r == '0) ? 7'd1 :
                 (led_count_r > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : led_count_r;
  assign in_full = q_full;

  lrrg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_req_type(in_req_type),
    .in_angle   (in_angle),
    .shift      (shift),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  lrrg_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lrrg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .shift           (shift),
    .count           (count),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_led_position(out_led_position),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last        (out_last)
  );

endmodule

// File: rtl/core/lrrg_front.sv
// Front end: accepts requests, keeps the wheel phase and forwards updates.
module lrrg_front
  import lrrg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_req_type,
  input  logic [ANGLE_W-1:0] in_angle,
  input  logic [1:0]         shift,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic               accept;
  logic [8:0]         span;
  logic [10:0]        base;
  logic [PHASE_W-1:0] new_phase;

  assign accept = in_push && !q_full;

  // 1536 * cycle * (256 - a) / 256 reduces to 6 * (256 - a) scaled by the cycle.
  assign span      = 9'd256 - {1'b0, in_angle[ANGLE_W-1:4]};
  assign base      = {span, 2'b00} + {1'b0, span, 1'b0};
  assign new_phase = {2'b00, base} << shift;

  always_comb begin
    phase_nxt = phase_r;
    if (accept && (req_type_t'(in_req_type) == REQ_SET_ANGLE)) begin
      phase_nxt = new_phase;
    end
  end

  assign q_push    = accept && (req_type_t'(in_req_type) == REQ_UPDATE);
  assign q_cmd.phase = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/core/lrrg_cmd_fifo.sv
// Two-entry request queue between the front and the back.
module lrrg_cmd_fifo
  import lrrg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/lrrg_back.sv
// Back end: divides the wheel pitch by the LED count and walks the ring.
module lrrg_back
  import lrrg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         shift,
  input  logic [COUNT_W-1:0] count,
  input  logic               q_empty,
  input  cmd_t               q_head,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [POS_W-1:0]   out_led_position,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t             state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] quo_r, quo_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [3:0]         div_cnt_r, div_cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [COUNT_W-1:0] frac_r, frac_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               valid_r, valid_nxt;
  logic [POS_W-1:0]   led_pos_r, led_pos_nxt;
  rgb_t               rgb_r, rgb_nxt;
  logic               last_r, last_nxt;

  logic [COUNT_W:0]   trial;
  logic               trial_ge;
  logic [COUNT_W:0]   frac_sum;
  logic               carry;
  logic [IDX_W:0]     idx_sum;
  logic               slot_free;
  logic               is_last;
  logic [COUNT_W-1:0] count_m1;

  assign trial     = {rem_r, quo_r[PHASE_W-1]};
  assign trial_ge  = (trial >= {1'b0, count});
  assign frac_sum  = {1'b0, frac_r} + {1'b0, rem_r};
  assign carry     = (frac_sum >= {1'b0, count});
  assign idx_sum   = {1'b0, idx_r} + {1'b0, step_r} + {{IDX_W{1'b0}}, carry};
  assign slot_free = !valid_r || out_pop;
  assign count_m1  = count - 7'd1;
  assign is_last   = ({1'b0, pos_r} == count_m1);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    frac_nxt    = frac_r;
    pos_nxt     = pos_r;
    valid_nxt   = valid_r && !out_pop;
    led_pos_nxt = led_pos_r;
    rgb_nxt     = rgb_r;
    last_nxt    = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          phase_nxt   = q_head.phase;
          quo_nxt     = WHEEL_STEPS_P << shift;
          rem_nxt     = '0;
          div_cnt_nxt = 4'd0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        quo_nxt     = {quo_r[PHASE_W-2:0], trial_ge};
        rem_nxt     = trial_ge ? COUNT_W'(trial - {1'b0, count}) : trial[COUNT_W-1:0];
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(PHASE_W - 1)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        idx_nxt   = wheel_mod(phase_r);
        step_nxt  = wheel_mod(quo_r);
        frac_nxt  = '0;
        pos_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          valid_nxt   = 1'b1;
          led_pos_nxt = pos_r;
          rgb_nxt     = wheel_rgb(idx_r);
          last_nxt    = is_last;
          // The remainder of the pitch accumulates and carries into the index.
          frac_nxt    = carry ? COUNT_W'(frac_sum - {1'b0, count}) : frac_sum[COUNT_W-1:0];
          idx_nxt     = (idx_sum >= {1'b0, WHEEL_STEPS}) ?
                        IDX_W'(idx_sum - {1'b0, WHEEL_STEPS}) : idx_sum[IDX_W-1:0];
          pos_nxt     = pos_r + 6'd1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    phase_r   <= phase_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    frac_r    <= frac_nxt;
    pos_r     <= pos_nxt;
    led_pos_r <= led_pos_nxt;
    rgb_r     <= rgb_nxt;
    last_r    <= last_nxt;
  end

  assign out_empty        = !valid_r;
  assign out_led_position = led_pos_r;
  assign out_red          = rgb_r.red;
  assign out_green        = rgb_r.green;
  assign out_blue         = rgb_r.blue;
  assign out_last         = last_r;

endmodule

// File: verif/led_ring_rainbow_generator_checker.sv
// Checker for the LED ring rainbow generator: predicts every color and compares it.
module led_ring_rainbow_generator_checker
  import lrrg_pkg::*;
#(
  parameter int MAX_LEDS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_req_type,
  input  logic [ANGLE_W-1:0]    in_angle,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [POS_W-1:0]      out_led_position,
  input  logic [COLOR_W-1:0]    out_red,
  input  logic [COLOR_W-1:0]    out_green,
  input  logic [COLOR_W-1:0]    out_blue,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending_colors,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } led_color_t;

  led_color_t         expected_colors[$];
  logic [MODE_W-1:0]  cycle_mode;
  logic [COUNT_W-1:0] led_count;
  logic [PHASE_W-1:0] wheel_phase;

  initial begin
    pending_colors = 0;
    fail_count     = 0;
  end

  function automatic led_color_t wheel_color(input int unsigned idx, input int unsigned pos,
                                             input bit last);
    led_color_t         c;
    logic [COLOR_W-1:0] up;
    logic [COLOR_W-1:0] down;
    up     = COLOR_W'(idx % 256);
    down   = 8'd255 - up;
    c.pos  = POS_W'(pos);
    c.last = last;
    case (idx / 256)
      0:       {c.red, c.green, c.blue} = {up, 8'd0, 8'd255};
      1:       {c.red, c.green, c.blue} = {8'd255, 8'd0, down};
      2:       {c.red, c.green, c.blue} = {8'd255, up, 8'd0};
      3:       {c.red, c.green, c.blue} = {down, 8'd255, 8'd0};
      4:       {c.red, c.green, c.blue} = {8'd0, 8'd255, up};
      default: {c.red, c.green, c.blue} = {8'd0, down, 8'd255};
    endcase
    return c;
  endfunction

  function automatic void predict_request(input logic req, input logic [ANGLE_W-1:0] angle);
    int unsigned reps;
    int unsigned count;
    int unsigned steps;
    int unsigned idx;
    // Mode three wraps around to a single repetition.
    reps = 1 << (cycle_mode % 3);
    if (req == REQ_SET_ANGLE) begin
      steps = angle >> 4;
      wheel_phase = PHASE_W'(1536 * reps * (256 - steps) / 256);
    end else begin
      count = led_count;
      if (count < 1) count = 1;
      if (count > MAX_LEDS) count = MAX_LEDS;
      for (int i = 0; i < count; i++) begin
        idx = (wheel_phase + 1536 * reps * i / count) % 1536;
        expected_colors.push_back(wheel_color(idx, i, i + 1 == count));
      end
    end
  endfunction

  function automatic void check_color();
    led_color_t got;
    led_color_t want;
    got = '{pos: out_led_position, red: out_red, green: out_green, blue: out_blue,
            last: out_last};
    if (expected_colors.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("Unexpected color: pos %0d rgb %0d/%0d/%0d last %0d",
                 got.pos, got.red, got.green, got.blue, got.last);
    end else begin
      want = expected_colors.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Color mismatch: expected pos %0d rgb %0d/%0d/%0d last %0d, got pos %0d rgb %0d/%0d/%0d last %0d",
                   want.pos, want.red, want.green, want.blue, want.last,
                   got.pos, got.red, got.green, got.blue, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_mode  = '0;
      led_count   = COUNT_W'(24);
      wheel_phase = '0;
      expected_colors.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CYCLE_MODE: cycle_mode = cfg_data[MODE_W-1:0];
          CFG_LED_COUNT:  led_count  = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_request(in_req_type, in_angle);
      if (out_pop && !out_empty) check_color();
    end
    pending_colors <= expected_colors.size();
  end

endmodule

// File: verif/led_ring_rainbow_generator_tb.sv
// Testbench top for the LED ring rainbow generator: clock, reset, stimulus and verdict.
module led_ring_rainbow_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrrg_pkg::*;

  localparam int LED_LIMIT     = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_push     = 1'b0;
  logic                  in_full;
  logic                  in_req_type = 1'b0;
  logic [ANGLE_W-1:0]    in_angle    = '0;
  logic                  out_empty;
  logic                  out_pop     = 1'b0;
  logic [POS_W-1:0]      out_led_position;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic                  out_last;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int          pending_colors;
  int          fail_count;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  led_ring_rainbow_generator #(.MAX_LEDS(LED_LIMIT)) i_dut (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_angle,
    .out_empty, .out_pop, .out_led_position, .out_red, .out_green, .out_blue, .out_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  led_ring_rainbow_generator_checker #(.MAX_LEDS(LED_LIMIT)) i_checker (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_angle,
    .out_empty, .out_pop, .out_led_position, .out_red, .out_green, .out_blue, .out_last,
    .cfg_we, .cfg_index, .cfg_data, .pending_colors, .fail_count
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input req_type_t req, input logic [ANGLE_W-1:0] angle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push     <= 1'b1;
    in_req_type <= req;
    in_angle    <= angle;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // A set-angle request leaves nothing to wait for, so a fixed settle time follows the drain.
  task automatic wait_for_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_colors != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input int mode, input int count);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CYCLE_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_LED_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int count_pick;
    logic [ANGLE_W-1:0] angle_pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then the wrap of mode three, the count clamps and the
    // largest phase, which exceeds one turn of the wheel.
    send_request(REQ_UPDATE, 12'd0);
    send_request(REQ_SET_ANGLE, 12'd0);
    send_request(REQ_UPDATE, 12'hFFF);
    send_request(REQ_SET_ANGLE, 12'hFFF);
    send_request(REQ_UPDATE, 12'd0);
    send_request(REQ_SET_ANGLE, 12'h00F);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(3, 0);
    send_request(REQ_SET_ANGLE, 12'h800);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(2, 64);
    send_request(REQ_SET_ANGLE, 12'd0);
    send_request(REQ_UPDATE, 12'd0);
    send_request(REQ_SET_ANGLE, 12'hFF0);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(1, 127);
    send_request(REQ_SET_ANGLE, 12'h400);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(0, 25);
    send_request(REQ_SET_ANGLE, 12'd3000);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(2, 1);
    send_request(REQ_UPDATE, 12'd0);
    reconfigure(1, 7);
    send_request(REQ_SET_ANGLE, 12'h5A5);
    send_request(REQ_UPDATE, 12'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct <= 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct <= 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(0, 5))
          0:       count_pick = 0;
          1:       count_pick = 1;
          2:       count_pick = LED_LIMIT;
          3:       count_pick = $urandom_range(LED_LIMIT + 1, 127);
          default: count_pick = $urandom_range(2, LED_LIMIT - 1);
        endcase
        reconfigure($urandom_range(0, 3), count_pick);
        for (int k = 0; k < 36; k++) begin
          if (phase == 0 && seg == 1 && k == 18) wait_for_results();
          case ($urandom_range(0, 9))
            0:       angle_pick = '0;
            1:       angle_pick = '1;
            default: angle_pick = ANGLE_W'($urandom);
          endcase
          if ($urandom_range(0, 99) < 55) send_request(REQ_UPDATE, angle_pick);
          else send_request(REQ_SET_ANGLE, angle_pick);
        end
      end
    end

    wait_for_results();
    if (fail_count == 0 && pending_colors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
